// ===== sv/lcc_pkg.sv =====
package lcc_pkg;

    localparam int COEFF_W = 32;           // input coefficient
    localparam int OUT_W   = 64;           // result coefficient
    localparam int MOD_W   = 31;           // modulus register
    localparam int BITS_W  = 5;            // target_bits register
    localparam int CFG_W   = 31;           // widest register
    localparam int IDX_W   = 2;            // register index
    localparam int MAX_BITS = 16;          // largest compressed width
    localparam int SHIFT_W  = 5;           // holds MAX_BITS + 1

    // |2^(d+1) * x + q| stays below 2^49
    localparam int DVD_W = 49;
    // divisor is 2q, below 2^32
    localparam int DVS_W = 32;
    // signed numerator before the magnitude is taken
    localparam int NUM_W = DVD_W + 1;
    // only the low bits of the quotient matter after the mod 2^d
    localparam int QKEEP_W = MAX_BITS;

    localparam logic [IDX_W-1:0] CFG_DIRECTION   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MODULUS     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_TARGET_BITS = 2'd2;

    localparam logic [MOD_W-1:0]  MODULUS_RESET = 31'd3329;
    localparam logic [BITS_W-1:0] BITS_RESET    = 5'd10;

    // sideband that rides along the divider
    typedef struct packed {
        logic signed [COEFF_W-1:0] x;
        logic                      last;
        logic                      neg;
    } lcc_side_t;

endpackage

// ===== sv/lcc_divider.sv =====
module lcc_divider
    import lcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DVD_W-1:0]     in_dividend,
    input  lcc_side_t            in_side,
    input  logic [DVS_W-1:0]     divisor,
    output logic                 out_valid,
    output logic [QKEEP_W-1:0]   out_quot,
    output logic                 out_rem_nz,
    output lcc_side_t            out_side
);

    // one quotient bit per stage, dividend consumed msb first
    logic                 vld_reg [DVD_W];
    logic [DVD_W-1:0]     dvd_reg [DVD_W];
    logic [DVS_W-1:0]     rem_reg [DVD_W];
    logic [QKEEP_W-1:0]   quo_reg [DVD_W];
    lcc_side_t            side_reg [DVD_W];

    for (genvar k = 0; k < DVD_W; k++) begin : g_stage
        logic               vld_prev;
        logic [DVD_W-1:0]   dvd_prev;
        logic [DVS_W-1:0]   rem_prev;
        logic [QKEEP_W-1:0] quo_prev;
        lcc_side_t          side_prev;
        logic [DVS_W:0]     trial;
        logic [DVS_W:0]     diff;
        logic               ge;
        logic [DVS_W-1:0]   rem_next;
        logic [QKEEP_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign dvd_prev  = in_dividend;
            assign rem_prev  = '0;
            assign quo_prev  = '0;
            assign side_prev = in_side;
        end else begin : g_chain
            assign vld_prev  = vld_reg[k-1];
            assign dvd_prev  = dvd_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial    = {rem_prev, dvd_prev[DVD_W-1-k]};
        assign diff     = trial - {1'b0, divisor};
        assign ge       = (trial >= {1'b0, divisor});
        assign rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        assign quo_next = {quo_prev[QKEEP_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvd_reg[k]  <= dvd_prev;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid  = vld_reg[DVD_W-1];
    assign out_quot   = quo_reg[DVD_W-1];
    assign out_rem_nz = |rem_reg[DVD_W-1];
    assign out_side   = side_reg[DVD_W-1];

endmodule

// ===== sv/lattice_coeff_compressor.sv =====
// lattice coefficient compress / decompress pipeline
//
// input beats (s_valid/s_ready) carry one signed coefficient and a last flag;
// every input beat yields exactly one output beat (m_valid/m_ready), in order,
// with last passed through unchanged.
// direction 0 compresses: round(2^d * x / q) taken mod 2^d and recentered to
// [-2^(d-1), 2^(d-1)-1]. direction 1 decompresses: round(q * x / 2^d).
// ties round upward. registers are written through cfg_wr_en/cfg_index/
// cfg_data and must only change while the pipeline is empty.
// throughput: one beat per cycle while the pipeline advances, through the
// 49-stage restoring divider (one quotient bit a stage) that does the
// division by 2q.
// reset clears all valid bits and loads direction 0, modulus 3329, d = 10.
// with m_valid high and m_ready low the whole pipeline holds; a one-entry skid
// buffer on the input takes one more beat, then s_ready drops until the output drains.
module lattice_coeff_compressor
    import lcc_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [COEFF_W-1:0]  s_coeff_in,
    input  logic                       s_last_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_W-1:0]    m_coeff_out,
    output logic                       m_last_out
);

    // configuration
    logic              dir_reg;
    logic [MOD_W-1:0]  mod_reg;
    logic [BITS_W-1:0] bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= 1'b0;
            mod_reg  <= MODULUS_RESET;
            bits_reg <= BITS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DIRECTION:   dir_reg  <= cfg_data[0];
                CFG_MODULUS:     mod_reg  <= cfg_data[MOD_W-1:0];
                CFG_TARGET_BITS: bits_reg <= cfg_data[BITS_W-1:0];
                default:         ;
            endcase
        end
    end

    logic [MOD_W-1:0]  q_eff;
    logic [BITS_W-1:0] d_eff;
    logic [SHIFT_W-1:0] d_plus1;
    logic [BITS_W-1:0] d_minus1;
    logic [DVS_W-1:0]  divisor;

    always_comb begin
        q_eff = (mod_reg < MOD_W'(2)) ? MOD_W'(2) : mod_reg;
        if (bits_reg == '0) begin
            d_eff = BITS_W'(1);
        end else if (bits_reg > BITS_W'(MAX_BITS)) begin
            d_eff = BITS_W'(MAX_BITS);
        end else begin
            d_eff = bits_reg;
        end
        d_plus1  = SHIFT_W'(d_eff) + SHIFT_W'(1);
        d_minus1 = d_eff - BITS_W'(1);
        divisor  = {q_eff, 1'b0};
    end

    // global advance: the output register is free or being emptied
    logic adv;
    assign adv = !m_valid || m_ready;

    // input skid
    logic                      skid_valid_reg;
    logic signed [COEFF_W-1:0] skid_coeff_reg;
    logic                      skid_last_reg;
    logic                      in_acc;

    assign s_ready = !skid_valid_reg;
    assign in_acc  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (adv) begin
            skid_valid_reg <= 1'b0;
        end else if (in_acc) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && in_acc) begin
            skid_coeff_reg <= s_coeff_in;
            skid_last_reg  <= s_last_in;
        end
    end

    logic                      src_valid;
    logic signed [COEFF_W-1:0] src_x;
    logic                      src_last;

    assign src_valid = skid_valid_reg || in_acc;
    assign src_x     = skid_valid_reg ? skid_coeff_reg : s_coeff_in;
    assign src_last  = skid_valid_reg ? skid_last_reg : s_last_in;

    // stage 1: numerator 2^(d+1) * x + q
    logic                      s1_valid_reg;
    logic signed [NUM_W-1:0]   s1_num_reg;
    logic signed [COEFF_W-1:0] s1_x_reg;
    logic                      s1_last_reg;
    logic signed [NUM_W-1:0]   x_ext;
    logic signed [NUM_W-1:0]   num_next;

    assign x_ext    = NUM_W'(src_x);
    assign num_next = (x_ext <<< d_plus1) + $signed({{(NUM_W-MOD_W){1'b0}}, q_eff});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_num_reg  <= num_next;
            s1_x_reg    <= src_x;
            s1_last_reg <= src_last;
        end
    end

    // stage 2: sign and magnitude for the unsigned divider
    logic               s2_valid_reg;
    logic [DVD_W-1:0]   s2_mag_reg;
    lcc_side_t          s2_side_reg;
    logic [NUM_W-1:0]   mag_full;

    assign mag_full = s1_num_reg[NUM_W-1] ? (-s1_num_reg) : s1_num_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_mag_reg       <= mag_full[DVD_W-1:0];
            s2_side_reg.x    <= s1_x_reg;
            s2_side_reg.last <= s1_last_reg;
            s2_side_reg.neg  <= s1_num_reg[NUM_W-1];
        end
    end

    // divider
    logic               dv_valid;
    logic [QKEEP_W-1:0] dv_quot;
    logic               dv_rem_nz;
    lcc_side_t          dv_side;

    lcc_divider u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (s2_valid_reg),
        .in_dividend (s2_mag_reg),
        .in_side     (s2_side_reg),
        .divisor     (divisor),
        .out_valid   (dv_valid),
        .out_quot    (dv_quot),
        .out_rem_nz  (dv_rem_nz),
        .out_side    (dv_side)
    );

    // finish 1: floor quotient low bits, or the decompress product
    logic                    f1_valid_reg;
    logic [OUT_W-1:0]        f1_val_reg;
    logic                    f1_last_reg;
    logic [QKEEP_W-1:0]      tlow;
    logic signed [COEFF_W-1:0] q_signed;
    logic signed [OUT_W-1:0] prod;
    logic [OUT_W-1:0]        f1_val_next;

    // negative numerator: floor = -(quot + (rem != 0))
    assign tlow     = dv_side.neg ? (~dv_quot + QKEEP_W'(!dv_rem_nz)) : dv_quot;
    assign q_signed = $signed({1'b0, q_eff});
    assign prod     = OUT_W'(q_signed) * OUT_W'(dv_side.x);
    assign f1_val_next = dir_reg ? prod : {{(OUT_W-QKEEP_W){1'b0}}, tlow};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_val_reg  <= f1_val_next;
            f1_last_reg <= dv_side.last;
        end
    end

    // finish 2: recenter, or round-and-shift
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_coeff_reg;
    logic                     out_last_reg;
    logic [QKEEP_W-1:0]       cmask;
    logic [QKEEP_W-1:0]       chalf;
    logic [QKEEP_W-1:0]       cred;
    logic signed [QKEEP_W:0]  crec;
    logic signed [OUT_W-1:0]  dsum;
    logic signed [OUT_W-1:0]  dres;
    logic signed [OUT_W-1:0]  coeff_next;

    always_comb begin
        cmask = QKEEP_W'(({1'b0, {QKEEP_W{1'b0}}} | (17'd1 << d_eff)) - 17'd1);
        chalf = QKEEP_W'(17'd1 << d_minus1);
        cred  = f1_val_reg[QKEEP_W-1:0] & cmask;
        crec  = $signed({1'b0, cred})
                - ((cred >= chalf) ? $signed(17'd1 << d_eff) : $signed(17'd0));
        dsum  = $signed(f1_val_reg) + $signed(64'd1 << d_minus1);
        dres  = dsum >>> d_eff;
        coeff_next = dir_reg ? dres : OUT_W'(crec);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_coeff_reg <= coeff_next;
            out_last_reg  <= f1_last_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_coeff_out = out_coeff_reg;
    assign m_last_out  = out_last_reg;

    // skid only fills on a cycle the pipeline was held
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(!adv))
        else $error("skid filled while pipeline advanced");

    // compressed values land in the recentered range
    a_comp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !dir_reg) |->
            (m_coeff_out >= -($signed(64'd1) <<< d_minus1)) &&
            (m_coeff_out <  ($signed(64'd1) <<< d_minus1)))
        else $error("compressed coefficient out of range");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

// ===== test/tb_lattice_coeff_compressor.sv =====
module tb_lattice_coeff_compressor;
    import lcc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NUM_DIRECTED = 22;
    localparam int NUM_FIXED    = 14;
    localparam int NUM_PHASES   = 20;
    localparam int PHASE_ITEMS  = 34;
    localparam int DRAIN_CYCLES = 60;
    localparam int STUCK_LIMIT  = 4000;

    typedef struct packed {
        logic signed [OUT_W-1:0] coeff;
        logic                    last;
    } coeff_result_t;

    typedef struct packed {
        logic                      dir;
        logic signed [COEFF_W-1:0] coeff;
        logic                      last;
        logic                      typed;
        logic signed [OUT_W-1:0]   want;
    } stim_row_t;

    typedef struct packed {
        logic              dir;
        logic [MOD_W-1:0]  modulus;
        logic [BITS_W-1:0] bits;
    } reg_set_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COEFF_W-1:0] s_coeff_in = '0;
    logic                      s_last_in = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [OUT_W-1:0]   m_coeff_out;
    logic                      m_last_out;

    // register shadow, starts at reset values
    logic              cur_dir = 1'b0;
    logic [MOD_W-1:0]  cur_mod = MODULUS_RESET;
    logic [BITS_W-1:0] cur_bits = BITS_RESET;

    coeff_result_t pending_q[$];
    int unsigned   mismatches = 0;
    int unsigned   stuck_cycles = 0;
    int unsigned   stall_left = 0;
    bit            steady = 1'b0;
    bit            valid_up = 1'b0;

    // rows with a typed value use the reset modulus 3329 and d = 10
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{1'b0, 32'sd0,           1'b0, 1'b1, 64'sd0},
        '{1'b0, 32'sd3329,        1'b1, 1'b1, 64'sd0},
        '{1'b0, 32'sd1,           1'b0, 1'b0, 64'sd0},
        '{1'b0, -32'sd1,          1'b0, 1'b0, 64'sd0},
        '{1'b0, 32'sd2,           1'b0, 1'b0, 64'sd0},
        '{1'b0, 32'sd1664,        1'b0, 1'b0, 64'sd0},
        '{1'b0, 32'sd1665,        1'b1, 1'b0, 64'sd0},
        '{1'b0, -32'sd1664,       1'b0, 1'b0, 64'sd0},
        '{1'b0, -32'sd3329,       1'b0, 1'b0, 64'sd0},
        '{1'b0, 32'sh7fffffff,    1'b0, 1'b0, 64'sd0},
        '{1'b0, 32'sh80000000,    1'b1, 1'b0, 64'sd0},
        '{1'b1, 32'sd0,           1'b0, 1'b1, 64'sd0},
        '{1'b1, 32'sd1024,        1'b0, 1'b1, 64'sd3329},
        '{1'b1, -32'sd1024,       1'b1, 1'b1, -64'sd3329},
        '{1'b1, 32'sd512,         1'b0, 1'b1, 64'sd1665},
        '{1'b1, -32'sd512,        1'b0, 1'b1, -64'sd1664},
        '{1'b1, 32'sd1,           1'b0, 1'b0, 64'sd0},
        '{1'b1, -32'sd1,          1'b0, 1'b0, 64'sd0},
        '{1'b1, 32'sd511,         1'b0, 1'b0, 64'sd0},
        '{1'b1, 32'sd1023,        1'b1, 1'b0, 64'sd0},
        '{1'b1, 32'sh7fffffff,    1'b0, 1'b0, 64'sd0},
        '{1'b1, 32'sh80000000,    1'b1, 1'b0, 64'sd0}
    };

    reg_set_t fixed_sets [NUM_FIXED] = '{
        '{1'b0, 31'd3329,        5'd10},
        '{1'b1, 31'd3329,        5'd10},
        '{1'b0, 31'd3329,        5'd1},
        '{1'b1, 31'd3329,        5'd1},
        '{1'b0, 31'd0,           5'd0},
        '{1'b1, 31'd1,           5'd31},
        '{1'b0, 31'd2,           5'd16},
        '{1'b1, 31'd2,           5'd16},
        '{1'b0, 31'h7fffffff,    5'd16},
        '{1'b1, 31'h7fffffff,    5'd16},
        '{1'b0, 31'h7fffffff,    5'd1},
        '{1'b1, 31'h7fffffff,    5'd17},
        '{1'b0, 31'd8380417,     5'd13},
        '{1'b1, 31'd8380417,     5'd13}
    };

    lattice_coeff_compressor uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_coeff_in  (s_coeff_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_coeff_out (m_coeff_out),
        .m_last_out  (m_last_out)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // compressed or decompressed value under the current register shadow
    function automatic longint scaled_coeff(logic signed [COEFF_W-1:0] x);
        longint q, xv, num, den, t, r, v;
        int d;
        d = cur_bits;
        if (d < 1) d = 1;
        if (d > MAX_BITS) d = MAX_BITS;
        q = cur_mod;
        if (q < 2) q = 2;
        xv = x;
        if (cur_dir) begin
            v = q * xv + (longint'(1) << (d - 1));
            return v >>> d;
        end
        num = (longint'(1) << (d + 1)) * xv + q;
        den = 2 * q;
        t = num / den;
        if ((num % den) != 0 && num < 0) t = t - 1;
        r = t & ((longint'(1) << d) - 1);
        if (r >= (longint'(1) << (d - 1))) r = r - (longint'(1) << d);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int unsigned pick_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 80) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(5, 60);
    endfunction

    function automatic logic signed [COEFF_W-1:0] rand_coeff();
        int unsigned pick, qe;
        logic signed [COEFF_W-1:0] v;
        pick = $urandom_range(0, 99);
        qe = (cur_mod < 2) ? 2 : cur_mod;
        if (pick < 40) begin
            v = $urandom;
        end else if (pick < 70) begin
            v = $urandom_range(0, qe);
        end else if (pick < 85) begin
            v = $urandom_range(0, 1 << MAX_BITS);
        end else begin
            case ($urandom_range(0, 4))
                0: v = 32'sh7fffffff;
                1: v = 32'sh80000000;
                2: v = 32'sd0;
                3: v = 32'sd1;
                default: v = -32'sd1;
            endcase
        end
        if (pick >= 40 && pick < 85 && $urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    // one input beat; the expectation is queued when the beat is taken
    task automatic send_coeff(input logic signed [COEFF_W-1:0] c, input logic l,
                              input logic typed, input logic signed [OUT_W-1:0] want);
        int unsigned gap;
        coeff_result_t res;
        gap = pick_gap();
        if (gap != 0 && valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
        repeat (gap) @(posedge aclk);
        s_valid    <= 1'b1;
        s_coeff_in <= c;
        s_last_in  <= l;
        valid_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        res.coeff = typed ? want : scaled_coeff(c);
        res.last  = l;
        pending_q.push_back(res);
    endtask

    task automatic finish_stream();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    // leaves cfg_wr_en high; the caller lowers it
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_DIRECTION:   cur_dir = val[0];
            CFG_MODULUS:     cur_mod = val[MOD_W-1:0];
            CFG_TARGET_BITS: cur_bits = val[BITS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic dir, input logic [MOD_W-1:0] modulus,
                             input logic [BITS_W-1:0] bits, input bit poke_unused);
        // upper data bits are don't-care for the narrow registers
        write_reg(CFG_DIRECTION, CFG_W'({$urandom, dir}));
        write_reg(CFG_MODULUS, modulus);
        write_reg(CFG_TARGET_BITS, CFG_W'({$urandom, bits}));
        if (poke_unused) write_reg(CFG_UNUSED, CFG_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge aclk) begin
        coeff_result_t head;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                $error("coeff_out: no beat expected, got %0d", m_coeff_out);
                mismatches++;
            end else begin
                head = pending_q.pop_front();
                if (m_coeff_out !== head.coeff) begin
                    $error("coeff_out: expected %0d, got %0d", head.coeff, m_coeff_out);
                    mismatches++;
                end
                if (m_last_out !== head.last) begin
                    $error("last_out: expected %0b, got %0b", head.last, m_last_out);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int unsigned nxt;
        if (!aresetn) begin
            stall_left <= 0;
            m_ready    <= 1'b0;
        end else begin
            nxt = (stall_left != 0) ? stall_left - 1 : pick_stall();
            stall_left <= nxt;
            m_ready    <= (nxt == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        reg_set_t rs;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].dir != cur_dir) begin
                finish_stream();
                configure(directed_rows[i].dir, cur_mod, cur_bits, 1'b0);
            end
            send_coeff(directed_rows[i].coeff, directed_rows[i].last,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            finish_stream();
            steady = (p % 4 == 3);
            if (p < NUM_FIXED) begin
                rs = fixed_sets[p];
            end else begin
                rs.dir = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0: rs.modulus = MOD_W'($urandom_range(2, 4096));
                    1: rs.modulus = MOD_W'($urandom_range(0, 1));
                    default: rs.modulus = MOD_W'($urandom);
                endcase
                rs.bits = BITS_W'($urandom_range(0, 31));
            end
            configure(rs.dir, rs.modulus, rs.bits, (p == 5) || (p >= NUM_FIXED));
            repeat (PHASE_ITEMS)
                send_coeff(rand_coeff(), $urandom_range(0, 7) == 0, 1'b0, '0);
        end

        finish_stream();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
